### hw/rtl/fgti_pkg.sv
// Shared types, constants and a saturating helper function of the trilinear field interpolator.
`timescale 1ns / 1ps
`default_nettype none

package fgti_pkg;

  // Fixed-point layout of the cell fractions and weights.
  localparam int FRAC_BITS = 12;
  localparam logic [12:0] FRAC_ONE = 13'd4096;

  // Item kinds on the input channel.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Axis codes used while locating a point.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_X_ORIGIN = 3'd0;
  localparam logic [2:0] CFG_Y_ORIGIN = 3'd1;
  localparam logic [2:0] CFG_Z_ORIGIN = 3'd2;
  localparam logic [2:0] CFG_X_STEP   = 3'd3;
  localparam logic [2:0] CFG_Y_STEP   = 3'd4;
  localparam logic [2:0] CFG_Z_STEP   = 3'd5;
  localparam logic [2:0] CFG_SCALE    = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       ld_mul;
    logic       ld_wr;
    logic       ax_lim;
    logic       ax_chk;
    logic       div_step;
    logic       ax_fix;
    logic       base1;
    logic       base2;
    logic       c_addr;
    logic       c_m1;
    logic       c_m2;
    logic       c_acc;
    logic       fin;
    logic [1:0] axis;
    logic [2:0] corner;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic outside;
    logic div_last;
    logic out_free;
  } sts_t;

  // Saturate a signed value to the 24-bit field range.
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fgti_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fgti_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 262144
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fgti_ctrl.sv
// Controller state machine that sequences loads and queries.
`timescale 1ns / 1ps
`default_nettype none

module fgti_ctrl import fgti_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_kind,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_LD_MUL = 14'b00000000000010,
    S_LD_WR  = 14'b00000000000100,
    S_AX_LIM = 14'b00000000001000,
    S_AX_CHK = 14'b00000000010000,
    S_AX_DIV = 14'b00000000100000,
    S_AX_FIX = 14'b00000001000000,
    S_BASE1  = 14'b00000010000000,
    S_BASE2  = 14'b00000100000000,
    S_C_ADDR = 14'b00001000000000,
    S_C_M1   = 14'b00010000000000,
    S_C_M2   = 14'b00100000000000,
    S_C_ACC  = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [2:0] corner_r, corner_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next-state logic and command decode.
  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    corner_nxt   = corner_r;
    cmd          = '0;
    cmd.axis     = axis_r;
    cmd.corner   = corner_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_nxt    = AXIS_X;
          corner_nxt  = 3'd0;
          state_nxt   = (in_kind == KIND_LOAD) ? S_LD_MUL : S_AX_LIM;
        end
      end
      S_LD_MUL: begin
        cmd.ld_mul = 1'b1;
        state_nxt  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_AX_LIM: begin
        cmd.ax_lim = 1'b1;
        state_nxt  = S_AX_CHK;
      end
      S_AX_CHK: begin
        cmd.ax_chk = 1'b1;
        state_nxt  = sts.outside ? S_FIN : S_AX_DIV;
      end
      S_AX_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_AX_FIX;
        end
      end
      S_AX_FIX: begin
        cmd.ax_fix = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_BASE1;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_AX_LIM;
        end
      end
      S_BASE1: begin
        cmd.base1 = 1'b1;
        state_nxt = S_BASE2;
      end
      S_BASE2: begin
        cmd.base2 = 1'b1;
        state_nxt = S_C_ADDR;
      end
      S_C_ADDR: begin
        cmd.c_addr = 1'b1;
        state_nxt  = S_C_M1;
      end
      S_C_M1: begin
        cmd.c_m1  = 1'b1;
        state_nxt = S_C_M2;
      end
      S_C_M2: begin
        cmd.c_m2  = 1'b1;
        state_nxt = S_C_ACC;
      end
      S_C_ACC: begin
        cmd.c_acc = 1'b1;
        if (corner_r == 3'd7) begin
          state_nxt = S_FIN;
        end else begin
          corner_nxt = corner_r + 3'd1;
          state_nxt  = S_C_ADDR;
        end
      end
      S_FIN: begin
        // Wait until the output register is free before handing over the beat.
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      axis_r   <= AXIS_X;
      corner_r <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      axis_r   <= axis_nxt;
      corner_r <= corner_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fgti_dp.sv
// Datapath: configuration registers, cell divider, weight multipliers and grid memory.
`timescale 1ns / 1ps
`default_nettype none

module fgti_dp import fgti_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int GRID_Z = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [17:0]        in_node_index,
  input  wire logic signed [23:0] in_node_bx,
  input  wire logic signed [23:0] in_node_by,
  input  wire logic signed [23:0] in_node_bz,
  input  wire logic signed [31:0] in_query_x,
  input  wire logic signed [31:0] in_query_y,
  input  wire logic signed [31:0] in_query_z,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic signed [23:0]      out_field_x,
  output logic signed [23:0]      out_field_y,
  output logic signed [23:0]      out_field_z,
  output logic                    out_in_range
);

  localparam int NODES = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(NODES);
  localparam int GXY   = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GMAX  = (GXY > GRID_Z) ? GXY : GRID_Z;
  localparam int QB    = $clog2(GMAX);
  localparam int QW    = QB + FRAC_BITS;
  localparam int CW    = 32 + QB;
  localparam int CNTW  = $clog2(QW);
  localparam int YZ    = GRID_Y * GRID_Z;

  // Configuration registers.
  logic signed [31:0] x_org_r, y_org_r, z_org_r;
  logic [30:0]        x_step_r, y_step_r, z_step_r;
  logic [15:0]        scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_org_r  <= '0;
      y_org_r  <= '0;
      z_org_r  <= '0;
      x_step_r <= 31'd1024;
      y_step_r <= 31'd1024;
      z_step_r <= 31'd1024;
      scale_r  <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_ORIGIN: x_org_r  <= cfg_data;
        CFG_Y_ORIGIN: y_org_r  <= cfg_data;
        CFG_Z_ORIGIN: z_org_r  <= cfg_data;
        CFG_X_STEP:   x_step_r <= cfg_data[30:0];
        CFG_Y_STEP:   y_step_r <= cfg_data[30:0];
        CFG_Z_STEP:   z_step_r <= cfg_data[30:0];
        CFG_SCALE:    scale_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Captured input beat.
  logic [17:0]        idx_r;
  logic signed [23:0] nb_r [3];
  logic signed [31:0] qx_r, qy_r, qz_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r   <= in_node_index;
      nb_r[0] <= in_node_bx;
      nb_r[1] <= in_node_by;
      nb_r[2] <= in_node_bz;
      qx_r    <= in_query_x;
      qy_r    <= in_query_y;
      qz_r    <= in_query_z;
    end
  end

  // Per-axis selection of point, origin, step and last index.
  logic signed [31:0] q_sel, org_sel;
  logic [30:0]        step_raw, step_eff;
  logic [QB-1:0]      nm1;

  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        q_sel = qx_r; org_sel = x_org_r; step_raw = x_step_r; nm1 = QB'(GRID_X - 1);
      end
      AXIS_Y: begin
        q_sel = qy_r; org_sel = y_org_r; step_raw = y_step_r; nm1 = QB'(GRID_Y - 1);
      end
      default: begin
        q_sel = qz_r; org_sel = z_org_r; step_raw = z_step_r; nm1 = QB'(GRID_Z - 1);
      end
    endcase
    step_eff = (step_raw == 31'd0) ? 31'd1 : step_raw;
  end

  // Offset from the origin and the upper bound of the grid on this axis.
  logic signed [32:0] d_r;
  logic [CW-1:0]      lim_r;
  logic               oor_r;

  always_ff @(posedge clk) begin
    if (cmd.ax_lim) begin
      d_r   <= 33'(q_sel) - 33'(org_sel);
      lim_r <= CW'(nm1) * CW'(step_eff);
    end
  end

  assign sts.outside = d_r[32] || ({QB'(0), d_r[31:0]} > lim_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      oor_r <= 1'b0;
    end else if (cmd.ax_chk && sts.outside) begin
      oor_r <= 1'b1;
    end
  end

  // Restoring divider: floor(d * 4096 / step), one quotient bit per cycle.
  logic [30:0]   div_rem_r;
  logic [QW-1:0] div_sh_r;
  logic [CNTW-1:0] div_cnt_r;
  logic [31:0]   div_trial, div_diff;
  logic          div_ge;

  assign div_trial    = {div_rem_r, div_sh_r[QW-1]};
  assign div_diff     = div_trial - {1'b0, step_eff};
  assign div_ge       = (div_trial >= {1'b0, step_eff});
  assign sts.div_last = (div_cnt_r == CNTW'(QW - 1));

  always_ff @(posedge clk) begin
    if (cmd.ax_chk) begin
      div_rem_r <= 31'($unsigned(d_r) >> QB);
      div_sh_r  <= {d_r[QB-1:0], FRAC_BITS'(0)};
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? div_diff[30:0] : div_trial[30:0];
      div_sh_r  <= {div_sh_r[QW-2:0], div_ge};
      div_cnt_r <= div_cnt_r + CNTW'(1);
    end
  end

  // Cell index and fraction; a point on the upper edge falls into the last cell.
  logic [QB-1:0] qi, cell_fix;
  logic [12:0]   t_fix;
  logic [QB-1:0] cx_r, cy_r, cz_r;
  logic [12:0]   tx_r, ty_r, tz_r;

  always_comb begin
    qi = div_sh_r[QW-1:FRAC_BITS];
    if (qi == nm1) begin
      cell_fix = nm1 - QB'(1);
      t_fix    = FRAC_ONE;
    end else begin
      cell_fix = qi;
      t_fix    = {1'b0, div_sh_r[FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ax_fix) begin
      case (cmd.axis)
        AXIS_X: begin cx_r <= cell_fix; tx_r <= t_fix; end
        AXIS_Y: begin cy_r <= cell_fix; ty_r <= t_fix; end
        default: begin cz_r <= cell_fix; tz_r <= t_fix; end
      endcase
    end
  end

  // Flat index of the lower corner, built in two steps.
  logic [AW-1:0] base_r;

  always_ff @(posedge clk) begin
    if (cmd.base1) begin
      base_r <= AW'(cx_r) * AW'(GRID_Y) + AW'(cy_r);
    end else if (cmd.base2) begin
      base_r <= base_r * AW'(GRID_Z) + AW'(cz_r);
    end
  end

  // Corner address and weights.
  logic [AW-1:0] corner_addr;
  logic [12:0]   wx, wy, wz;
  logic [25:0]   wxy;
  logic [24:0]   wxy_r;
  logic [12:0]   wz_r;

  always_comb begin
    corner_addr = base_r
                + (cmd.corner[2] ? AW'(YZ) : AW'(0))
                + (cmd.corner[1] ? AW'(GRID_Z) : AW'(0))
                + AW'(cmd.corner[0]);
    wx  = cmd.corner[2] ? tx_r : (FRAC_ONE - tx_r);
    wy  = cmd.corner[1] ? ty_r : (FRAC_ONE - ty_r);
    wz  = cmd.corner[0] ? tz_r : (FRAC_ONE - tz_r);
    wxy = 26'(wx) * 26'(wy);
  end

  always_ff @(posedge clk) begin
    if (cmd.c_addr) begin
      wxy_r <= wxy[24:0];
      wz_r  <= wz;
    end
  end

  // Grid memory.
  logic          ld_idx_ok;
  logic [31:0]   idx32;
  logic [71:0]   mem_wdata, mem_rdata;
  logic signed [40:0] ld_prod_r [3];
  logic signed [40:0] ld_shift  [3];
  logic signed [23:0] ld_sat    [3];

  assign idx32     = 32'(idx_r);
  assign ld_idx_ok = (idx32 < 32'(NODES));

  fgti_ram #(
    .WIDTH(72),
    .DEPTH(NODES)
  ) u_grid (
    .clk    (clk),
    .we     (cmd.ld_wr && ld_idx_ok),
    .waddr  (idx32[AW-1:0]),
    .wdata  (mem_wdata),
    .re     (cmd.c_addr),
    .raddr  (corner_addr),
    .rdata_r(mem_rdata)
  );

  // Load lanes: scale, floor by 4096 and saturate.
  always_ff @(posedge clk) begin
    if (cmd.ld_mul) begin
      for (int k = 0; k < 3; k++) begin
        ld_prod_r[k] <= nb_r[k] * $signed({1'b0, scale_r});
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ld_shift[k] = ld_prod_r[k] >>> FRAC_BITS;
      ld_sat[k]   = sat24(64'(ld_shift[k]));
    end
    mem_wdata = {ld_sat[2], ld_sat[1], ld_sat[0]};
  end

  // Interpolation lanes: two multiplies then accumulate.
  logic signed [49:0] p1_r  [3];
  logic signed [61:0] p2_r  [3];
  logic signed [61:0] acc_r [3];
  logic signed [23:0] rd_comp [3];
  logic signed [61:0] acc_adj [3];
  logic signed [25:0] acc_q   [3];
  logic signed [23:0] res     [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_comp[k] = mem_rdata[24*k +: 24];
      // Division by 2^36 truncating toward zero.
      acc_adj[k] = acc_r[k] + (acc_r[k][61] ? 62'sh0_000f_ffff_ffff : 62'sd0);
      acc_q[k]   = 26'(acc_adj[k] >>> 36);
      res[k]     = sat24(64'(acc_q[k]));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.c_m1) begin
        p1_r[k] <= rd_comp[k] * $signed({1'b0, wxy_r});
      end
      if (cmd.c_m2) begin
        // The full product needs up to 60 bits, so it is formed at the register width.
        p2_r[k] <= p1_r[k] * $signed({1'b0, wz_r});
      end
      if (cmd.capture) begin
        acc_r[k] <= '0;
      end else if (cmd.c_acc) begin
        acc_r[k] <= acc_r[k] + p2_r[k];
      end
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_field_x  <= oor_r ? 24'sd0 : res[0];
      out_field_y  <= oor_r ? 24'sd0 : res[1];
      out_field_z  <= oor_r ? 24'sd0 : res[2];
      out_in_range <= !oor_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

### hw/rtl/field_grid_trilinear_interp.sv
// Top level of the trilinear field interpolator on a uniform 3-D grid.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, kind, node, query    | input beat
//   out     | out_valid/out_ready, field_x/y/z, range | result beat
//   cfg     | cfg_valid/cfg_ready, cfg_index, data    | register write
//
// A load passes a multiply state and a write state; it writes one grid word if its index
// lies inside the grid and gives no result. A query runs the shared restoring divider
// once per axis (one quotient bit per cycle), then visits each corner over the single
// read port of the grid memory; a point outside finishes early.
// Reset is synchronous and active low; the grid contents are not cleared.
// A stalled result sits in the output register while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module field_grid_trilinear_interp import fgti_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int GRID_Z = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [17:0]        in_node_index,
  input  wire logic signed [23:0] in_node_bx,
  input  wire logic signed [23:0] in_node_by,
  input  wire logic signed [23:0] in_node_bz,
  input  wire logic signed [31:0] in_query_x,
  input  wire logic signed [31:0] in_query_y,
  input  wire logic signed [31:0] in_query_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_field_x,
  output logic signed [23:0]      out_field_y,
  output logic signed [23:0]      out_field_z,
  output logic                    out_in_range,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fgti_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_kind (in_kind),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fgti_dp #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_node_index(in_node_index),
    .in_node_bx   (in_node_bx),
    .in_node_by   (in_node_by),
    .in_node_bz   (in_node_bz),
    .in_query_x   (in_query_x),
    .in_query_y   (in_query_y),
    .in_query_z   (in_query_z),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_field_x  (out_field_x),
    .out_field_y  (out_field_y),
    .out_field_z  (out_field_z),
    .out_in_range (out_in_range)
  );

`ifndef NO_ASSERTIONS
  // A query beat keeps the input side closed on the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_QUERY) |=> !in_ready)
    else $error("input accepted while a query is in progress");

  // A result appears only when the controller hands one over.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.fin))
    else $error("result beat without a finish command");

  // A point outside the grid reports a zero field.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_field_x == 24'sd0 && out_field_y == 24'sd0 && out_field_z == 24'sd0))
    else $error("non-zero field for a point outside the grid");

  // Memory writes and corner reads never overlap.
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ld_wr && cmd.c_addr))
    else $error("grid write and read issued together");
`endif

endmodule

`default_nettype wire

### dv/tb_field_grid_trilinear_interp.sv
// Self-checking testbench for the trilinear field interpolator on a uniform grid.
`timescale 1ns / 1ps

module tb_field_grid_trilinear_interp;
  import fgti_pkg::*;

  localparam int GX = 64;
  localparam int GY = 64;
  localparam int GZ = 64;
  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 150;
  localparam longint I32_MAX = 64'sd2147483647;

  typedef struct {
    logic              kind;
    logic [17:0]       idx;
    logic signed [23:0] b [3];
    logic signed [31:0] q [3];
  } item_t;

  typedef struct {
    logic signed [23:0] f [3];
    logic               in_range;
  } field_t;

  typedef struct {
    logic signed [23:0] c [3];
  } node_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_kind = 1'b0;
  logic [17:0] in_node_index = '0;
  logic signed [23:0] in_node_bx = '0, in_node_by = '0, in_node_bz = '0;
  logic signed [31:0] in_query_x = '0, in_query_y = '0, in_query_z = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  wire in_ready, out_valid, cfg_ready, out_in_range;
  wire signed [23:0] out_field_x, out_field_y, out_field_z;

  field_grid_trilinear_interp #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) dut (.*);

  always #5 clk = ~clk;

  // Grid and register copy used to work out the expected fields.
  node_t  grid_mem [int];
  longint grid_org [3];
  longint grid_step [3];
  longint gain;
  int     dims [3] = '{GX, GY, GZ};

  // Nodes that the stimulus has already scheduled a load for.
  bit     loaded_plan [int];

  item_t  pending_items [$];
  field_t expected_fields [$];
  int     error_count = 0;
  int     items_made = 0;
  bit     quiet = 1'b0;

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Finds the cell and Q1.12 fraction along one axis; returns 0 if the point is outside.
  function automatic bit find_cell(input longint q, input int ax, output int cidx,
                                   output longint frac);
    longint s, d, i;
    s = (grid_step[ax] == 0) ? 64'sd1 : grid_step[ax];
    d = q - grid_org[ax];
    cidx = 0;
    frac = 0;
    if (d < 0 || d > (dims[ax] - 1) * s) return 1'b0;
    i = d / s;
    if (i > dims[ax] - 2) i = dims[ax] - 2;
    cidx = int'(i);
    frac = ((d - i * s) * 4096) / s;
    return 1'b1;
  endfunction

  function automatic int node_at(input int x, input int y, input int z);
    return (x * GY + y) * GZ + z;
  endfunction

  // Updates the grid for a load or queues the interpolated field for a query.
  function automatic void interpolate_item(input item_t it);
    int     cid [3];
    longint t [3];
    longint acc [3];
    longint w;
    bit     in_grid;
    node_t  nd;
    field_t res;
    if (it.kind == KIND_LOAD) begin
      for (int k = 0; k < 3; k++) nd.c[k] = clamp24((longint'(it.b[k]) * gain) >>> 12);
      if (it.idx < GX * GY * GZ) grid_mem[int'(it.idx)] = nd;
      return;
    end
    in_grid = 1'b1;
    for (int a = 0; a < 3; a++) in_grid &= find_cell(longint'(it.q[a]), a, cid[a], t[a]);
    res.in_range = in_grid;
    for (int k = 0; k < 3; k++) acc[k] = 0;
    if (in_grid) begin
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          for (int c = 0; c < 2; c++) begin
            w = (a ? t[0] : 4096 - t[0]) * (b ? t[1] : 4096 - t[1]) *
                (c ? t[2] : 4096 - t[2]);
            nd.c = '{default: '0};
            if (grid_mem.exists(node_at(cid[0] + a, cid[1] + b, cid[2] + c)))
              nd = grid_mem[node_at(cid[0] + a, cid[1] + b, cid[2] + c)];
            for (int k = 0; k < 3; k++) acc[k] += longint'(nd.c[k]) * w;
          end
    end
    for (int k = 0; k < 3; k++) res.f[k] = clamp24(acc[k] / (64'sd1 <<< 36));
    expected_fields.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Input driver: presents one beat at a time from the pending queue.
  item_t cur_item;
  int    in_gap = 0;
  always @(posedge clk) begin
    item_t nx;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) interpolate_item(cur_item);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nx = pending_items.pop_front();
          cur_item <= nx;
          in_kind <= nx.kind;
          in_node_index <= nx.idx;
          in_node_bx <= nx.b[0];
          in_node_by <= nx.b[1];
          in_node_bz <= nx.b[2];
          in_query_x <= nx.q[0];
          in_query_y <= nx.q[1];
          in_query_z <= nx.q[2];
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %0s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result monitor: random back-pressure and a field-by-field compare per beat.
  int out_stall = 0;
  always @(posedge clk) begin
    field_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fields.size() == 0) begin
          report_mismatch("unexpected beat, in_range", out_in_range, -1);
        end else begin
          want = expected_fields.pop_front();
          if (out_field_x !== want.f[0]) report_mismatch("field_x", out_field_x, want.f[0]);
          if (out_field_y !== want.f[1]) report_mismatch("field_y", out_field_y, want.f[1]);
          if (out_field_z !== want.f[2]) report_mismatch("field_z", out_field_z, want.f[2]);
          if (out_in_range !== want.in_range)
            report_mismatch("in_range", out_in_range, want.in_range);
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_fields.size());
        $display("** field_grid_trilinear_interp: FAILED **");
        $finish;
      end
    end
  end

  // One register write; the copy is updated on the accepting edge.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_ORIGIN: grid_org[0] = longint'($signed(data));
      CFG_Y_ORIGIN: grid_org[1] = longint'($signed(data));
      CFG_Z_ORIGIN: grid_org[2] = longint'($signed(data));
      CFG_X_STEP:   grid_step[0] = longint'(data[30:0]);
      CFG_Y_STEP:   grid_step[1] = longint'(data[30:0]);
      CFG_Z_STEP:   grid_step[2] = longint'(data[30:0]);
      CFG_SCALE:    gain = longint'(data[15:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic push_load(input int idx, input logic signed [23:0] bx,
                           input logic signed [23:0] by, input logic signed [23:0] bz);
    item_t it;
    it.kind = KIND_LOAD;
    it.idx = idx[17:0];
    it.b = '{bx, by, bz};
    it.q = '{$urandom, $urandom, $urandom};
    loaded_plan[idx] = 1'b1;
    pending_items.push_back(it);
    items_made++;
  endtask

  function automatic logic signed [23:0] rand_field();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 24'sh7fffff;
    if (r == 1) return 24'sh800000;
    return 24'($urandom);
  endfunction

  // Queues a query, first loading any corner of its cell not yet loaded.
  task automatic push_query(input logic signed [31:0] qx, input logic signed [31:0] qy,
                            input logic signed [31:0] qz);
    item_t  it;
    int     cid [3];
    longint t;
    bit     in_grid;
    in_grid = 1'b1;
    it.q = '{qx, qy, qz};
    for (int a = 0; a < 3; a++) in_grid &= find_cell(longint'(it.q[a]), a, cid[a], t);
    if (in_grid)
      for (int n = 0; n < 8; n++)
        if (!loaded_plan.exists(node_at(cid[0] + n[2], cid[1] + n[1], cid[2] + n[0])))
          push_load(node_at(cid[0] + n[2], cid[1] + n[1], cid[2] + n[0]),
                    rand_field(), rand_field(), rand_field());
    it.kind = KIND_QUERY;
    it.idx = 18'($urandom);
    it.b = '{24'($urandom), 24'($urandom), 24'($urandom)};
    pending_items.push_back(it);
    items_made++;
  endtask

  // A coordinate inside the grid, mostly in the first cells and the last one.
  function automatic logic signed [31:0] inside_coord(input int ax);
    longint s, base, top, off;
    int c, r;
    s = (grid_step[ax] == 0) ? 64'sd1 : grid_step[ax];
    r = $urandom_range(99);
    c = (r < 65) ? $urandom_range(2) : (r < 85) ? dims[ax] - 2 : $urandom_range(dims[ax] - 2);
    while (grid_org[ax] + c * s > I32_MAX) c = c / 2;
    base = grid_org[ax] + c * s;
    top = (c == dims[ax] - 2) ? s : s - 1;
    if (top > I32_MAX - base) top = I32_MAX - base;
    r = $urandom_range(99);
    if (r < 20) off = 0;
    else if (r < 35) off = top;
    else off = longint'({$urandom, $urandom} >> 1) % (top + 1);
    return 32'(base + off);
  endfunction

  // Mostly loads and queries on a few cells, with stray loads and wild points mixed in.
  task automatic random_items(input int count);
    int stop, r;
    stop = items_made + count;
    while (items_made < stop) begin
      r = $urandom_range(99);
      if (r < 10) push_load($urandom_range(GX * GY * GZ - 1), rand_field(), rand_field(),
                            rand_field());
      else if (r < 22) push_query($urandom, $urandom, $urandom);
      else push_query(inside_coord(0), inside_coord(1), inside_coord(2));
    end
  endtask

  // Waits until every beat has gone and the block has had time to settle.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_fields.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                           input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
                           input logic [31:0] sc);
    write_reg(CFG_X_ORIGIN, ox);
    write_reg(CFG_Y_ORIGIN, oy);
    write_reg(CFG_Z_ORIGIN, oz);
    write_reg(CFG_X_STEP, sx);
    write_reg(CFG_Y_STEP, sy);
    write_reg(CFG_Z_STEP, sz);
    write_reg(CFG_SCALE, sc);
  endtask

  initial begin
    grid_org = '{0, 0, 0};
    grid_step = '{1024, 1024, 1024};
    gain = 4096;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings.
    push_load(0, 24'sh7fffff, 24'sh800000, 24'sh000000);
    push_load(GX * GY * GZ - 1, 24'sh800000, 24'sh800000, 24'sh800000);
    for (int n = 1; n < 8; n++)
      push_load(node_at(n[2], n[1], n[0]), 24'sh7fffff, 24'sh800000, 24'sh7fffff);
    push_query(0, 0, 0);
    push_query(511, 1023, 1);
    push_query(63 * 1024, 63 * 1024, 63 * 1024);
    push_query(-1, 0, 0);
    push_query(0, 63 * 1024 + 1, 0);
    push_query(0, 0, 32'sh80000000);
    push_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_query(62 * 1024, 62 * 1024 + 512, 63 * 1024 - 1);
    random_items(150);
    drain();

    // Extreme settings with no idling at all.
    quiet = 1'b1;
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff,
              32'h7fffffff, 32'hffffffff);
    write_reg(CFG_SPARE, $urandom);
    random_items(120);
    drain();
    quiet = 1'b0;

    // Origin at the top, a zero step, unit step and a zero gain.
    write_all(32'h7fffffff, 32'h00000000, $urandom, 32'h80000000, 32'h00000001,
              $urandom_range(4096, 1), 32'hffff0000);
    random_items(100);
    drain();

    // Random moderate settings.
    for (int p = 0; p < 2; p++) begin
      write_all($urandom_range(200000) - 100000, $urandom_range(200000) - 100000,
                $urandom_range(200000) - 100000, {1'($urandom), 31'($urandom_range(5000, 1))},
                {1'($urandom), 31'($urandom_range(5000, 1))},
                {1'($urandom), 31'($urandom_range(5000, 1))},
                $urandom);
      write_reg(CFG_SPARE, $urandom);
      random_items(130);
      drain();
    end

    if (error_count == 0) begin
      $display("** field_grid_trilinear_interp: PASSED **");
    end else begin
      $display("** field_grid_trilinear_interp: FAILED **");
    end
    $finish;
  end

endmodule
